// ===== rtl/tcf_pkg.sv =====
// ----------------------------------------------------------------------------
// tcf_pkg
// shared types and constants of the texel channel to float converter
// ----------------------------------------------------------------------------
package tcf_pkg;

   localparam int RawWidth     = 32;
   localparam int TypeWidth    = 3;
   localparam int ChanWidth    = 6;
   localparam int PatWidth     = 64;
   localparam int RepMaxWidth  = 24;
   localparam int SmallExpBits = 5;
   localparam int SmallExpMax  = 31;
   localparam int F32Bias      = 127;
   localparam int F32MantBits  = 23;
   localparam int F32ExpMax    = (1 << 8) - 1;

   localparam logic [31:0] NanBits    = 32'h7FC0_0000;
   localparam logic [31:0] NegOneBits = 32'hBF80_0000;

   typedef enum logic [TypeWidth-1:0] {
      CT_UNORM  = 3'd0,
      CT_SNORM  = 3'd1,
      CT_SFLOAT = 3'd2,
      CT_UFLOAT = 3'd3,
      CT_UINT   = 3'd4,
      CT_SINT   = 3'd5,
      CT_RSVD6  = 3'd6,
      CT_RSVD7  = 3'd7
   } chan_type_type;

   // item in flight through the divide path
   typedef struct packed {
      logic                  bypass;
      logic [31:0]           bits;
      logic                  bad;
      logic                  rep;
      logic                  sign;
      logic [ChanWidth-1:0]  w;
      logic [7:0]            ebase;
      logic [PatWidth-1:0]   pat;
   } pipe_type;

   typedef struct packed {
      logic                  bypass;
      logic [31:0]           bits;
      logic                  bad;
      logic                  sign;
      logic [7:0]            exp;
      logic [23:0]           frac;
      logic                  sticky;
   } norm_type;

   typedef struct packed {
      logic [31:0] bits;
      logic        bad;
   } result_type;

endpackage

// ===== rtl/tcf_decode.sv =====
// ----------------------------------------------------------------------------
// tcf_decode
// masks the code, decodes type and width, expands small floats and sets up
// magnitude and exponent base for the normalized path
// ----------------------------------------------------------------------------
module tcf_decode
   import tcf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [RawWidth-1:0]  raw_bits,
   input  logic [TypeWidth-1:0] channel_type,
   input  logic [ChanWidth-1:0] channel_width,
   input  logic                 is_signed,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pipe_type             out_data
);

   logic          valid_ff;
   pipe_type      data_ff;
   pipe_type      data_in;
   chan_type_type ctype;

   logic [31:0] mask;
   logic [31:0] code;
   logic        width_ok;
   logic [5:0]  m_w;
   logic        neg;
   logic [31:0] mag;
   logic [31:0] small_bits;
   logic [3:0]  mb;
   logic        s_sign;
   logic [4:0]  s_exp;
   logic [10:0] s_mant;
   logic [3:0]  s_top;
   logic [10:0] s_rem;
   logic [31:0] s_e32;
   logic [31:0] s_m32;

   assign ctype    = chan_type_type'(channel_type);
   assign width_ok = (channel_width >= 6'd1) && (channel_width <= 6'd32);
   assign mask     = 32'((64'(1) << channel_width) - 64'(1));
   assign code     = raw_bits & mask;
   assign m_w      = channel_width - 6'd1;
   assign neg      = code[m_w[4:0]];

   // small float expansion
   always_comb begin
      mb     = 4'(channel_width - 6'(SmallExpBits) - 6'(is_signed));
      s_sign = 1'(code >> (SmallExpBits + int'(mb)));
      s_exp  = 5'(code >> mb);
      s_mant = 11'(code & ((32'(1) << mb) - 32'(1)));
      s_top  = 4'd0;
      for (int i = 0; i < 11; i++) begin
         if (s_mant[i]) s_top = 4'(i);
      end
      s_rem = s_mant & ~(11'(1) << s_top);
      s_e32 = 32'(F32Bias - 14) - 32'(mb) + 32'(s_top);
      s_m32 = 32'(s_rem) << (F32MantBits - int'(s_top));
      if (s_exp == 5'd0 && s_mant == 11'd0) begin
         small_bits = {s_sign, 31'd0};
      end else if (s_exp == 5'd0) begin
         small_bits = {s_sign, s_e32[7:0], s_m32[22:0]};
      end else if (s_exp != 5'(SmallExpMax)) begin
         s_e32      = 32'(s_exp) + 32'(F32Bias - 15);
         s_m32      = 32'(s_mant) << (F32MantBits - int'(mb));
         small_bits = {s_sign, s_e32[7:0], s_m32[22:0]};
      end else if (s_mant == 11'd0) begin
         small_bits = {s_sign, 8'(F32ExpMax), 23'd0};
      end else begin
         small_bits = {s_sign, 8'(F32ExpMax), 23'd1};
      end
   end

   always_comb begin
      mag              = code;
      data_in.bypass   = 1'b1;
      data_in.bits     = NanBits;
      data_in.bad      = 1'b1;
      data_in.rep      = 1'b0;
      data_in.sign     = 1'b0;
      data_in.w        = channel_width;
      data_in.ebase    = 8'd126;
      data_in.pat      = '0;
      if (width_ok) begin
         unique case (ctype)
            CT_UNORM: begin
               data_in.bad    = 1'b0;
               data_in.bypass = (code == 32'd0);
               data_in.bits   = 32'd0;
               data_in.rep    = (channel_width <= 6'(RepMaxWidth));
               data_in.w      = channel_width;
            end
            CT_SNORM: begin
               if (channel_width >= 6'd2) begin
                  mag = neg ? 32'((33'(1) << channel_width) - 33'(code)) : code;
                  data_in.bad    = 1'b0;
                  data_in.sign   = neg;
                  data_in.rep    = (m_w <= 6'(RepMaxWidth));
                  data_in.w      = m_w;
                  data_in.bits   = 32'd0;
                  data_in.bypass = (mag == 32'd0);
                  if (neg && data_in.rep && mag == (32'(1) << m_w[4:0])) begin
                     data_in.bypass = 1'b1;
                     data_in.bits   = NegOneBits;
                  end
               end
            end
            CT_SFLOAT, CT_UFLOAT: begin
               if (channel_width == 6'd32) begin
                  data_in.bad  = 1'b0;
                  data_in.bits = code;
               end else if (channel_width == 6'd10 || channel_width == 6'd11 ||
                            channel_width == 6'd16) begin
                  data_in.bad  = 1'b0;
                  data_in.bits = small_bits;
               end
            end
            default: begin
               data_in.bad = 1'b1;
            end
         endcase
      end
      data_in.ebase = data_in.rep ? 8'd126 : 8'(8'd158 - 8'(data_in.w));
      data_in.pat   = {mag, 32'd0};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

`ifndef SYNTHESIS
   a_bad_type: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && channel_type >= 3'(CT_UINT) |=> valid_ff && data_ff.bad)
      else $error("unsupported type not flagged");
`endif

endmodule

// ===== rtl/tcf_replicate.sv =====
// ----------------------------------------------------------------------------
// tcf_replicate
// repeats the w-bit magnitude across the pattern word when rep is set, giving the
// binary expansion of magnitude / (2^w - 1); one group of doubling steps per instance
// ----------------------------------------------------------------------------
module tcf_replicate
   import tcf_pkg::*;
#(
   parameter int  FIRST_STEP = 0,
   parameter int  NUM_STEPS  = 3,
   parameter bit  ALIGN      = 1'b1
)
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pipe_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output pipe_type out_data
);

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;
   logic [PatWidth-1:0] t;

   always_comb begin
      data_in = in_data;
      t       = in_data.pat;
      if (in_data.rep) begin
         if (ALIGN) begin
            t = t << (6'd32 - in_data.w);
         end
         for (int j = FIRST_STEP; j < FIRST_STEP + NUM_STEPS; j++) begin
            t = t | (t >> (12'(in_data.w) << j));
         end
      end
      data_in.pat = t;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/tcf_normalize.sv =====
// ----------------------------------------------------------------------------
// tcf_normalize
// leading zero count and left shift of the pattern word, exponent and sticky
// ----------------------------------------------------------------------------
module tcf_normalize
   import tcf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  pipe_type in_data,
   output logic     out_valid,
   input  logic     out_ready,
   output norm_type out_data
);

   logic     valid_ff;
   norm_type data_ff;
   norm_type data_in;
   logic [5:0]          lz;
   logic [PatWidth-1:0] sh;

   always_comb begin
      lz = 6'd0;
      for (int i = 0; i < PatWidth; i++) begin
         if (in_data.pat[i]) lz = 6'(PatWidth - 1 - i);
      end
      sh             = in_data.pat << lz;
      data_in.bypass = in_data.bypass;
      data_in.bits   = in_data.bits;
      data_in.bad    = in_data.bad;
      data_in.sign   = in_data.sign;
      data_in.exp    = in_data.ebase - 8'(lz);
      data_in.frac   = sh[62:39];
      data_in.sticky = (|sh[38:0]) || in_data.rep;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

`ifndef SYNTHESIS
   a_leading_one: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready && !in_data.bypass |=> valid_ff && data_ff.exp >= 8'd95)
      else $error("normalized exponent out of range");
`endif

endmodule

// ===== rtl/tcf_round.sv =====
// ----------------------------------------------------------------------------
// tcf_round
// round to nearest even and pack the single-precision result
// ----------------------------------------------------------------------------
module tcf_round
   import tcf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  norm_type   in_data,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_data
);

   logic       valid_ff;
   result_type data_ff;
   result_type data_in;
   logic       up;
   logic [30:0] sum;

   always_comb begin
      up  = in_data.frac[0] && (in_data.sticky || in_data.frac[1]);
      sum = {in_data.exp, in_data.frac[23:1]} + 31'(up);
      data_in.bad  = in_data.bad;
      data_in.bits = in_data.bypass ? in_data.bits : {in_data.sign, sum};
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/texture_channel_to_float_top.sv =====
// ----------------------------------------------------------------------------
// texture_channel_to_float_top
// converts one texel channel code to IEEE single-precision bits
// ----------------------------------------------------------------------------
// req channel carries a transaction of raw code, width, type and sign flag;
// rsp channel returns the float bits and an unsupported flag
// unorm and snorm divide by 2^n-1 (2^(n-1)-1) with single rounding, snorm
// clamps at -1, float32 passes through, 10/11/16-bit floats expand exactly
// unsupported types or widths return quiet nan with tuser set
// five register stages: decode, two pattern replication stages, normalize
// and round; throughput is one transaction per cycle while rsp_tready is high
// each stage holds its transaction while the next one is full, so a stall on
// rsp_tready fills the pipeline and then drops req_tready; bubbles collapse
// synchronous reset clears all stage valid bits; data registers are not reset
// ----------------------------------------------------------------------------
module texture_channel_to_float_top
   import tcf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // raw_bits[31:0], channel_width[37:32], zero pad
   input  logic [3:0]  req_tuser,   // channel_type[2:0], is_signed[3]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // float_bits[31:0]
   output logic        rsp_tuser    // unsupported
);

   logic       v1, v2, v3, v4;
   logic       r2, r3, r4, r5;
   pipe_type   d1, d2, d3;
   norm_type   d4;
   result_type d5;

   tcf_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .raw_bits      (req_tdata[31:0]),
      .channel_type  (req_tuser[2:0]),
      .channel_width (req_tdata[37:32]),
      .is_signed     (req_tuser[3]),
      .out_valid     (v1),
      .out_ready     (r2),
      .out_data      (d1)
   );

   tcf_replicate #(.FIRST_STEP(0), .NUM_STEPS(3), .ALIGN(1'b1)) u_rep_a (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v1),
      .in_ready  (r2),
      .in_data   (d1),
      .out_valid (v2),
      .out_ready (r3),
      .out_data  (d2)
   );

   tcf_replicate #(.FIRST_STEP(3), .NUM_STEPS(3), .ALIGN(1'b0)) u_rep_b (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v2),
      .in_ready  (r3),
      .in_data   (d2),
      .out_valid (v3),
      .out_ready (r4),
      .out_data  (d3)
   );

   tcf_normalize u_normalize (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v3),
      .in_ready  (r4),
      .in_data   (d3),
      .out_valid (v4),
      .out_ready (r5),
      .out_data  (d4)
   );

   tcf_round u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4),
      .in_ready  (r5),
      .in_data   (d4),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (d5)
   );

   assign rsp_tdata = d5.bits;
   assign rsp_tuser = d5.bad;

`ifndef SYNTHESIS
   a_nan_on_bad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == NanBits)
      else $error("unsupported transaction without quiet nan");
   a_no_ready_when_full: assert property (@(posedge clock) disable iff (reset)
      v1 && v2 && v3 && v4 && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("accepted into a full pipeline");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the texel channel to float converter: directed
// corner codes then random channel codes, checked against a float predictor
// ----------------------------------------------------------------------------
module tb;
   import tcf_pkg::*;

   class float_scoreboard;
      result_type pending[$];
      int         errors = 0;

      // single-precision bits to real, normal values and zero only
      static function real f32_to_real(logic [31:0] b);
         logic [63:0] d;
         if (b[30:0] == 31'd0) begin
            d = {b[31], 63'd0};
         end else begin
            d = {b[31], 11'(b[30:23] - 127 + 1023), b[22:0], 29'd0};
         end
         return $bitstoreal(d);
      endfunction

      // round a real to nearest-even single precision, normal range only
      static function logic [31:0] real_to_f32(real x);
         logic [63:0] d;
         logic [52:0] m;
         logic [24:0] m24;
         logic [28:0] rest;
         int          e;
         d = $realtobits(x);
         if (d[62:0] == 63'd0) return {d[63], 31'd0};
         m    = {1'b1, d[51:0]};
         m24  = {1'b0, m[52:29]};
         rest = m[28:0];
         e    = int'(d[62:52]) - 1023 + 127;
         if (rest > 29'h1000_0000 || (rest == 29'h1000_0000 && m24[0])) m24 = m24 + 1;
         if (m24[24]) begin
            m24 = m24 >> 1;
            e++;
         end
         return {d[63], 8'(e), m24[22:0]};
      endfunction

      static function logic [31:0] expand_small(logic [31:0] code, int mb);
         logic        s;
         logic [4:0]  e;
         logic [31:0] m;
         int          k;
         s = code[SmallExpBits + mb];
         e = 5'(code >> mb);
         m = code & ((32'd1 << mb) - 1);
         if (e == 0 && m == 0) return {s, 31'd0};
         if (e == 0) begin
            k = 0;
            while (k < 31 && (m >> (k + 1)) != 0) k++;
            return {s, 8'(F32Bias - 14 - mb + k), 23'((m - (32'd1 << k)) << (F32MantBits - k))};
         end
         if (e < SmallExpMax) return {s, 8'(e + F32Bias - 15), 23'(m << (F32MantBits - mb))};
         if (m == 0) return {s, 8'(F32ExpMax), 23'd0};
         return {s, 8'(F32ExpMax), 23'd1};
      endfunction

      static function result_type convert(logic [31:0] raw, chan_type_type ct,
                                          logic [5:0] n, logic sgn);
         result_type  r;
         logic [63:0] mask;
         logic [31:0] code;
         longint      v;
         real         q;
         r.bits = NanBits;
         r.bad  = 1'b1;
         if (n >= 1 && n <= 32) begin
            mask = (64'd1 << n) - 1;
            code = raw & mask[31:0];
            if (ct == CT_UNORM) begin
               q = f32_to_real(real_to_f32(real'(code))) /
                   f32_to_real(real_to_f32(real'(mask)));
               r.bits = real_to_f32(q);
               r.bad  = 1'b0;
            end else if (ct == CT_SNORM && n >= 2) begin
               v = longint'(code);
               if (code[n - 1]) v = v - (longint'(1) << n);
               q = f32_to_real(real_to_f32(real'(v))) /
                   f32_to_real(real_to_f32(real'((longint'(1) << (n - 1)) - 1)));
               r.bits = real_to_f32(q);
               if (q < -1.0) r.bits = NegOneBits;
               r.bad = 1'b0;
            end else if (ct == CT_SFLOAT || ct == CT_UFLOAT) begin
               if (n == 32) begin
                  r.bits = code;
                  r.bad  = 1'b0;
               end else if (n == 10 || n == 11 || n == 16) begin
                  r.bits = expand_small(code, n - SmallExpBits - sgn);
                  r.bad  = 1'b0;
               end
            end
         end
         return r;
      endfunction

      function void note_request(logic [31:0] raw, logic [2:0] ct, logic [5:0] n, logic sgn);
         pending.push_back(convert(raw, chan_type_type'(ct), n, sgn));
      endfunction

      function void check_response(logic [31:0] bits, logic bad);
         result_type exp_r;
         if (pending.size() == 0) begin
            $error("unexpected transaction: float_bits %h unsupported %b", bits, bad);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (bits !== exp_r.bits) begin
            $error("float_bits expected %h actual %h", exp_r.bits, bits);
            errors++;
         end
         if (bad !== exp_r.bad) begin
            $error("unsupported expected %b actual %b", exp_r.bad, bad);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // raw_bits[31:0], channel_width[37:32], zero pad
   logic [3:0]  req_tuser;   // channel_type[2:0], is_signed[3]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // float_bits[31:0]
   logic        rsp_tuser;   // unsupported

   float_scoreboard sb;
   int send_idle_pct;
   int recv_idle_pct;
   int hold_request;
   int quiet_cycles;

   texture_channel_to_float_top DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic send_item(logic [31:0] raw, logic [2:0] ct, logic [5:0] n, logic sgn);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, n, raw};
      req_tuser  <= {sgn, ct};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(raw, ct, n, sgn);
   endtask

   task automatic send_random();
      logic [31:0] raw;
      logic [2:0]  ct;
      logic [5:0]  n;
      int          pick;
      raw  = $urandom();
      pick = $urandom_range(99);
      if (pick < 30) begin
         ct = CT_UNORM;
         n  = 6'($urandom_range(32, 1));
      end else if (pick < 60) begin
         ct = CT_SNORM;
         n  = 6'($urandom_range(32, 1));
      end else if (pick < 90) begin
         ct = ($urandom_range(1)) ? CT_SFLOAT : CT_UFLOAT;
         case ($urandom_range(4))
            0: n = 6'd10;
            1: n = 6'd11;
            2: n = 6'd16;
            3: n = 6'd32;
            default: n = 6'($urandom_range(63));
         endcase
      end else begin
         ct = 3'($urandom_range(7));
         n  = 6'($urandom_range(63));
      end
      // bias small floats toward zero and subnormal exponents
      if (n != 32 && $urandom_range(3) == 0) raw = raw & ~(32'h1F << (n - 5 - 1));
      send_item(raw, ct, n, 1'($urandom_range(1)));
   endtask

   // result side
   initial begin
      int hold;
      hold = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold = hold_request;
            hold_request = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata, rsp_tuser);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 5000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      hold_request = 0;
      quiet_cycles = 0;
      send_idle_pct = 7;
      recv_idle_pct = 47;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_item(32'hFFFF_FFFF, CT_UNORM, 6'd1, 1'b0);
      send_item(32'hFFFF_FFFF, CT_UNORM, 6'd32, 1'b0);
      send_item(32'h0000_0080, CT_UNORM, 6'd8, 1'b1);
      send_item(32'h0000_0000, CT_UNORM, 6'd32, 1'b0);
      send_item(32'h0000_0080, CT_SNORM, 6'd8, 1'b0);
      send_item(32'h0000_007F, CT_SNORM, 6'd8, 1'b0);
      send_item(32'h0000_0001, CT_SNORM, 6'd1, 1'b0);
      send_item(32'h8000_0000, CT_SNORM, 6'd32, 1'b0);
      send_item(32'h7FFF_FFFF, CT_SNORM, 6'd32, 1'b1);
      send_item(32'h0000_0002, CT_SNORM, 6'd2, 1'b0);
      send_item(32'hC0A0_1234, CT_SFLOAT, 6'd32, 1'b0);
      send_item(32'h7FC1_2345, CT_UFLOAT, 6'd32, 1'b1);
      send_item(32'h0000_8000, CT_SFLOAT, 6'd16, 1'b1);
      send_item(32'h0000_0001, CT_SFLOAT, 6'd16, 1'b1);
      send_item(32'h0000_7C00, CT_SFLOAT, 6'd16, 1'b1);
      send_item(32'h0000_FE01, CT_SFLOAT, 6'd16, 1'b1);
      send_item(32'h0000_07C5, CT_UFLOAT, 6'd11, 1'b0);
      send_item(32'h0000_001F, CT_UFLOAT, 6'd10, 1'b0);
      send_item(32'h0000_03FF, CT_SFLOAT, 6'd10, 1'b1);
      send_item(32'h0000_0ABC, CT_SFLOAT, 6'd12, 1'b0);
      send_item(32'h0000_0001, CT_UINT, 6'd8, 1'b0);
      send_item(32'h0000_0001, CT_SINT, 6'd8, 1'b0);
      send_item(32'h0000_0001, CT_RSVD6, 6'd8, 1'b1);
      send_item(32'h0000_0001, CT_RSVD7, 6'd8, 1'b0);
      send_item(32'h0000_0001, CT_UNORM, 6'd0, 1'b0);
      send_item(32'hFFFF_FFFF, CT_UNORM, 6'd33, 1'b0);
      send_item(32'hFFFF_FFFF, CT_SNORM, 6'd63, 1'b1);

      repeat (600) send_random();
      send_idle_pct = 47;
      recv_idle_pct = 7;
      repeat (600) send_random();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = 80;
      repeat (700) send_random();
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
